[rtl/core/cwg_pkg.sv]
// Shared constants for the convolution window gatherer: field widths,
// configuration register indexes, reset values and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package cwg_pkg;

    // Parameter defaults for the top level.
    localparam int IMAGE_WORDS_DEF = 16384;
    localparam int MAX_KERNEL_DEF  = 8;
    localparam int MAX_SIDE_DEF    = 64;

    // Field widths of the input and result beats.
    localparam int ADDR_IN_W = 14;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 6;
    localparam int CHAN_W    = 4;
    localparam int COL_IDX_W = 10;

    // Configuration port and register widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int DEPTH_W    = 5;
    localparam int SIDE_CFG_W = 7;
    localparam int KCFG_W     = 4;
    localparam int STRIDE_W   = 4;
    localparam int PAD_W      = 3;

    // Signed image coordinates: out position times stride plus kernel offset
    // stays well inside this range.
    localparam int COORD_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [DEPTH_W-1:0]    DEPTH_RST  = 5'd1;
    localparam logic [SIDE_CFG_W-1:0] HEIGHT_RST = 7'd8;
    localparam logic [SIDE_CFG_W-1:0] WIDTH_RST  = 7'd8;
    localparam logic [KCFG_W-1:0]     KSIZE_RST  = 4'd3;
    localparam logic [STRIDE_W-1:0]   STRIDE_RST = 4'd1;
    localparam logic [PAD_W-1:0]      PAD_RST    = 3'd0;

    // Input beat actions.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_WINDOW = 1'b1;

endpackage

[rtl/core/cwg_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module cwg_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/conv_window_gather.sv]
// Top level of the im2col window gatherer: image store, address sequencer
// with one shared multiply-add unit, and the tap output stage.
// Depends on cwg_pkg and cwg_ram.
`timescale 1ns / 1ps

// Usage:
// A command is taken at a clock edge where start is high and busy is low.
// With action low it writes word_value into the image store at word_addr;
// busy never rises and no result follows. With action high it requests
// the window at (out_row, out_col) of channel chan. A request first runs
// its setup steps on the shared multiply-add unit (plane size, channel
// base, window origin, row base, column index base), then walks the
// K*K taps, reading the image store for each tap that is not padding;
// busy stays high until the walk ends. Taps come out in row-major order,
// one beat per cycle marked by tap_valid. Each beat is on the ports for
// one cycle only; the receiver cannot stall, so it must take every beat.
// The last beat of a window carries last. A zero window size gives no beats.
// The configuration port writes one register per cycle; the user must write
// it only while idle, which the block itself does not enforce. Reset sets
// the registers to their defaults and returns the sequencer to idle; the
// image store is not cleared and must be written before use.
module conv_window_gather #(
    parameter int IMAGE_WORDS = cwg_pkg::IMAGE_WORDS_DEF,
    parameter int MAX_KERNEL  = cwg_pkg::MAX_KERNEL_DEF,
    parameter int MAX_SIDE    = cwg_pkg::MAX_SIDE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cfg_we,
    input  logic [cwg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             action,
    input  logic [cwg_pkg::ADDR_IN_W-1:0]    word_addr,
    input  logic [cwg_pkg::WORD_W-1:0]       word_value,
    input  logic [cwg_pkg::POS_W-1:0]        out_row,
    input  logic [cwg_pkg::POS_W-1:0]        out_col,
    input  logic [cwg_pkg::CHAN_W-1:0]       chan,
    output logic                             tap_valid,
    output logic [cwg_pkg::WORD_W-1:0]       tap_value,
    output logic [cwg_pkg::COL_IDX_W-1:0]    column_index,
    output logic                             is_padding,
    output logic                             last
);

    import cwg_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int PLANE_W = 2 * SIDE_W;
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int MA_W    = COORD_W;
    localparam int MB_W    = PLANE_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = ((SIDE_W + 11 > PLANE_W + 4) ? SIDE_W + 11 : PLANE_W + 4) + 2;
    localparam int RAM_AW  = $clog2(IMAGE_WORDS);
    localparam int FLAT_CMP_W = ACC_W + 17;
    localparam logic [FLAT_CMP_W-1:0] WORDS_LIM = FLAT_CMP_W'(IMAGE_WORDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [2:0] STEP_PLANE   = 3'd0;
    localparam logic [2:0] STEP_CHBASE  = 3'd1;
    localparam logic [2:0] STEP_ROWOFS  = 3'd2;
    localparam logic [2:0] STEP_COLOFS  = 3'd3;
    localparam logic [2:0] STEP_ROWBASE = 3'd4;
    localparam logic [2:0] STEP_KSQ     = 3'd5;
    localparam logic [2:0] STEP_COLBASE = 3'd6;
    localparam logic [2:0] STEP_FINISH  = 3'd7;

    // Configuration registers.
    logic [DEPTH_W-1:0]    depth_reg;
    logic [SIDE_CFG_W-1:0] height_reg;
    logic [SIDE_CFG_W-1:0] width_reg;
    logic [KCFG_W-1:0]     ksize_reg;
    logic [STRIDE_W-1:0]   stride_reg;
    logic [PAD_W-1:0]      pad_reg;

    // Sequencer.
    logic [1:0] state_reg;
    logic [2:0] step_reg;
    logic       accept;

    // Request fields.
    logic [CHAN_W-1:0] chan_reg;
    logic [POS_W-1:0]  orow_reg;
    logic [POS_W-1:0]  ocol_reg;

    // Shared multiply-add unit.
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  mul_c;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  mul_next;
    logic signed [ACC_W-1:0]  mul_reg;

    // Window geometry.
    logic [SIDE_W-1:0]         h_cl;
    logic [SIDE_W-1:0]         w_cl;
    logic [KW-1:0]             k_cl;
    logic signed [COORD_W-1:0] h_s;
    logic signed [COORD_W-1:0] w_s;
    logic signed [ACC_W-1:0]   chbase_reg;
    logic signed [COORD_W-1:0] y0_reg;
    logic signed [COORD_W-1:0] x0_reg;
    logic signed [ACC_W-1:0]   row_reg;
    logic [COL_IDX_W-1:0]      col_reg;

    // Tap walk.
    logic [KW-1:0]             ky_reg;
    logic [KW-1:0]             kx_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic                      kx_end;
    logic                      ky_end;
    logic                      ch_ok;
    logic                      y_ok;
    logic                      x_ok;
    logic signed [ACC_W-1:0]   flat;
    logic                      flat_ok;
    logic                      tap_hit;

    // Output stage.
    logic                 out_vld_reg;
    logic                 out_pad_reg;
    logic [COL_IDX_W-1:0] out_col_reg;
    logic                 out_last_reg;

    // Image store ports.
    logic              ram_we;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign h_cl = (int'(height_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(height_reg);
    assign w_cl = (int'(width_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(width_reg);
    assign k_cl = (int'(ksize_reg) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ksize_reg);
    assign h_s  = COORD_W'(h_cl);
    assign w_s  = COORD_W'(w_cl);

    // Operand selection for the multiply-add unit, one product per setup step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        unique case (step_reg)
            STEP_PLANE:
            begin
                mul_a = MA_W'(h_cl);
                mul_b = MB_W'(w_cl);
            end
            STEP_CHBASE:
            begin
                mul_a = MA_W'(chan_reg);
                mul_b = MB_W'(mul_reg);
            end
            STEP_ROWOFS:
            begin
                mul_a = MA_W'(orow_reg);
                mul_b = MB_W'(stride_reg);
                mul_c = ACC_W'(0) - ACC_W'(pad_reg);
            end
            STEP_COLOFS:
            begin
                mul_a = MA_W'(ocol_reg);
                mul_b = MB_W'(stride_reg);
                mul_c = ACC_W'(0) - ACC_W'(pad_reg);
            end
            STEP_ROWBASE:
            begin
                mul_a = y0_reg;
                mul_b = MB_W'(w_cl);
                mul_c = chbase_reg;
            end
            STEP_KSQ:
            begin
                mul_a = MA_W'(k_cl);
                mul_b = MB_W'(k_cl);
            end
            STEP_COLBASE:
            begin
                mul_a = MA_W'(chan_reg);
                mul_b = MB_W'(mul_reg);
            end
            STEP_FINISH:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign mul_next = ACC_W'(prod) + mul_c;

    // Tap classification for the current walk position.
    assign kx_end  = ((kx_reg + KW'(1)) == k_cl);
    assign ky_end  = ((ky_reg + KW'(1)) == k_cl);
    assign ch_ok   = ({1'b0, chan_reg} < depth_reg);
    assign y_ok    = !y_reg[COORD_W-1] && (y_reg < h_s);
    assign x_ok    = !x_reg[COORD_W-1] && (x_reg < w_s);
    assign flat    = row_reg + ACC_W'(x_reg);
    assign flat_ok = !flat[ACC_W-1] && (FLAT_CMP_W'(flat[ACC_W-1:0]) < WORDS_LIM);
    assign tap_hit = ch_ok && y_ok && x_ok && flat_ok;

    assign ram_we    = accept && (action == ACT_WRITE) && (int'(word_addr) < IMAGE_WORDS);
    assign ram_re    = (state_reg == ST_RUN) && tap_hit;
    assign ram_raddr = RAM_AW'(flat[ACC_W-1:0]);

    cwg_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (IMAGE_WORDS)
    ) u_image_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (RAM_AW'(word_addr)),
        .wdata (word_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DEPTH_RST;
            height_reg <= HEIGHT_RST;
            width_reg  <= WIDTH_RST;
            ksize_reg  <= KSIZE_RST;
            stride_reg <= STRIDE_RST;
            pad_reg    <= PAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEPTH:  depth_reg  <= DEPTH_W'(cfg_data);
                CFG_HEIGHT: height_reg <= SIDE_CFG_W'(cfg_data);
                CFG_WIDTH:  width_reg  <= SIDE_CFG_W'(cfg_data);
                CFG_KSIZE:  ksize_reg  <= KCFG_W'(cfg_data);
                CFG_STRIDE: stride_reg <= STRIDE_W'(cfg_data);
                CFG_PAD:    pad_reg    <= PAD_W'(cfg_data);
                default:    depth_reg  <= depth_reg;
            endcase
        end
    end

    // Sequencer, walk counters and output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_PLANE;
            ky_reg      <= '0;
            kx_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= (state_reg == ST_RUN);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (action == ACT_WINDOW))
                    begin
                        state_reg <= ST_SETUP;
                        step_reg  <= STEP_PLANE;
                    end
                end
                ST_SETUP:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_FINISH)
                    begin
                        ky_reg    <= '0;
                        kx_reg    <= '0;
                        state_reg <= (k_cl == '0) ? ST_IDLE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (kx_end)
                    begin
                        kx_reg <= '0;
                        ky_reg <= ky_reg + KW'(1);
                        if (ky_end)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        kx_reg <= kx_reg + KW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; their contents only matter while the sequencer uses them.
    always_ff @(posedge clk)
    begin
        mul_reg      <= mul_next;
        out_pad_reg  <= !tap_hit;
        out_col_reg  <= col_reg;
        out_last_reg <= kx_end && ky_end;

        if (accept && (action == ACT_WINDOW))
        begin
            chan_reg <= chan;
            orow_reg <= out_row;
            ocol_reg <= out_col;
        end

        if (state_reg == ST_SETUP)
        begin
            // Each step captures the product issued in the step before it.
            unique case (step_reg)
                STEP_ROWOFS:  chbase_reg <= mul_reg;
                STEP_COLOFS:  y0_reg     <= COORD_W'(mul_reg);
                STEP_ROWBASE: x0_reg     <= COORD_W'(mul_reg);
                STEP_KSQ:     row_reg    <= mul_reg;
                STEP_FINISH:
                begin
                    col_reg <= COL_IDX_W'(mul_reg);
                    y_reg   <= y0_reg;
                    x_reg   <= x0_reg;
                end
                default:      col_reg    <= col_reg;
            endcase
        end
        else if (state_reg == ST_RUN)
        begin
            col_reg <= col_reg + COL_IDX_W'(1);
            if (kx_end)
            begin
                x_reg   <= x0_reg;
                y_reg   <= y_reg + COORD_W'(1);
                row_reg <= row_reg + ACC_W'(w_cl);
            end
            else
            begin
                x_reg <= x_reg + COORD_W'(1);
            end
        end
    end

    assign tap_valid    = out_vld_reg;
    assign tap_value    = out_pad_reg ? '0 : ram_rdata;
    assign column_index = out_col_reg;
    assign is_padding   = out_pad_reg;
    assign last         = out_last_reg;

endmodule
